// ===== rtl/core/mvd_pkg.sv =====
`default_nettype none
package mvd_pkg;

  localparam int VECTOR_MAX = 1024;
  localparam int ADDR_W     = $clog2(VECTOR_MAX);
  localparam int LEN_W      = 11;
  localparam int LEN_EFF_W  = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;
  localparam int COL_W      = 16;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET  = 11'd1024;
  localparam logic [COL_W-1:0] COLS_RESET = 16'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAC  = 1'b1;

  // Per-element control that travels with a matrix element down the pipe
  typedef struct packed {
    logic             first;
    logic             col_end;
    logic             last;
    logic [COL_W-1:0] col;
  } mvd_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/mvd_if.sv =====
`default_nettype none
interface mvd_in_if
  import mvd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, func, operand_value, input ready);
  modport sink   (input valid, func, operand_value, output ready);
endinterface

interface mvd_out_if
  import mvd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic        [COL_W-1:0]  column_index;
  logic                     last_column;

  modport source (output valid, out_value, column_index, last_column, input ready);
  modport sink   (input valid, out_value, column_index, last_column, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/matrix_vector_dot_engine.sv =====
// Channel   Dir  Payload                                   Handshake
// in_chan   in   func, operand_value (Q16.16)              valid/ready
// out_chan  out  out_value (Q16.16), column_index,         valid/ready
//                last_column
// cfg_*     in   cfg_index selects register, cfg_data      cfg_we, no wait
//
// One transaction enters per cycle while in_chan.ready is high. A column
// result reaches the output register after its last matrix element is
// accepted, through store read, multiply, accumulate, Q16.16 conversion.
// in_chan.ready drops only while a finished column sits in the accumulate
// stage and the output register still holds an untaken result.
// Synchronous active-low reset clears counters and valids; the vector
// store is not cleared and must be loaded before use.
`default_nettype none
module matrix_vector_dot_engine
  import mvd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mvd_in_if.sink                     in_chan,
  mvd_out_if.source                  out_chan
);

  logic              adv;
  logic              accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] vec_rd;
  logic              s1_valid;
  mvd_ctl_t          s1_ctl;
  logic [DATA_W-1:0] s1_operand;

  // Take a transaction whenever the pipe advances
  assign in_chan.ready = adv;
  assign accept        = in_chan.valid && adv;

  mvd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .adv        (adv),
    .func       (in_chan.func),
    .operand    (in_chan.operand_value),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .s1_valid   (s1_valid),
    .s1_ctl     (s1_ctl),
    .s1_operand (s1_operand)
  );

  // Vector elements; a read issued with the element it serves
  mvd_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_chan.operand_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (vec_rd)
  );

  mvd_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ctl     (s1_ctl),
    .s1_operand (s1_operand),
    .s1_vec     (vec_rd),
    .adv        (adv),
    .res        (out_chan)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mvd_store.sv =====
`default_nettype none
module mvd_store
  import mvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [VECTOR_MAX];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/mvd_ctrl.sv =====
`default_nettype none
module mvd_ctrl
  import mvd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  accept,
  input  wire logic                  adv,
  input  wire logic                  func,
  input  wire logic [DATA_W-1:0]     operand,
  output logic                       mem_we,
  output logic      [ADDR_W-1:0]     mem_waddr,
  output logic                       mem_re,
  output logic      [ADDR_W-1:0]     mem_raddr,
  output logic                       s1_valid,
  output mvd_ctl_t                   s1_ctl,
  output logic      [DATA_W-1:0]     s1_operand
);

  logic [LEN_W-1:0]     vlen_r;
  logic [COL_W-1:0]     cols_r;
  logic [ADDR_W-1:0]    load_idx_r, load_idx_nxt;
  logic [ADDR_W-1:0]    red_idx_r, red_idx_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [LEN_EFF_W-1:0] len_eff;
  logic [COL_W:0]       cols_eff;
  logic [ADDR_W-1:0]    pos;
  logic [LEN_EFF_W-1:0] pos_inc;
  logic                 red_end;
  logic                 col_last;
  logic                 s1_valid_r;
  mvd_ctl_t             s1_ctl_r, ctl_nxt;
  logic [DATA_W-1:0]    s1_operand_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= LEN_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECTOR_LENGTH: vlen_r <= cfg_data[LEN_W-1:0];
        REG_COLUMN_COUNT:  cols_r <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vlen_r == '0) begin
      len_eff = LEN_EFF_W'(1);
    end else if (int'(vlen_r) > VECTOR_MAX) begin
      len_eff = LEN_EFF_W'(VECTOR_MAX);
    end else begin
      len_eff = LEN_EFF_W'(vlen_r);
    end
    cols_eff = (cols_r == '0) ? (COL_W+1)'(1) : {1'b0, cols_r};

    pos     = (LEN_EFF_W'(load_idx_r) >= len_eff) ? '0 : load_idx_r;
    pos_inc = LEN_EFF_W'(pos) + LEN_EFF_W'(1);

    red_end  = (LEN_EFF_W'(red_idx_r) + LEN_EFF_W'(1)) >= len_eff;
    col_last = ({1'b0, col_r} + (COL_W+1)'(1)) >= cols_eff;

    ctl_nxt.first   = (red_idx_r == '0);
    ctl_nxt.col_end = red_end;
    ctl_nxt.last    = col_last;
    ctl_nxt.col     = col_r;

    load_idx_nxt = load_idx_r;
    red_idx_nxt  = red_idx_r;
    col_nxt      = col_r;
    if (accept) begin
      if (func == FUNC_LOAD) begin
        // a load at position zero restarts the reduction
        if (pos == '0) begin
          red_idx_nxt = '0;
          col_nxt     = '0;
        end
        load_idx_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
      end else begin
        if (red_end) begin
          red_idx_nxt = '0;
          col_nxt     = col_last ? '0 : col_r + COL_W'(1);
        end else begin
          red_idx_nxt = red_idx_r + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      red_idx_r  <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      load_idx_r <= load_idx_nxt;
      red_idx_r  <= red_idx_nxt;
      col_r      <= col_nxt;
      if (adv) begin
        s1_valid_r <= accept && (func == FUNC_MAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r     <= ctl_nxt;
      s1_operand_r <= operand;
    end
  end

  assign mem_we     = accept && (func == FUNC_LOAD);
  assign mem_waddr  = pos;
  assign mem_re     = accept && (func == FUNC_MAC);
  assign mem_raddr  = red_idx_r;
  assign s1_valid   = s1_valid_r;
  assign s1_ctl     = s1_ctl_r;
  assign s1_operand = s1_operand_r;

endmodule
`default_nettype wire

// ===== rtl/core/mvd_mac.sv =====
`default_nettype none
module mvd_mac
  import mvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire mvd_ctl_t          s1_ctl,
  input  wire logic [DATA_W-1:0] s1_operand,
  input  wire logic [DATA_W-1:0] s1_vec,
  output logic                   adv,
  mvd_out_if.source              res
);

  logic                    s2_valid_r;
  mvd_ctl_t                s2_ctl_r;
  logic signed [ACC_W-1:0] prod_r;
  logic                    s3_emit_r;
  logic [COL_W-1:0]        s3_col_r;
  logic                    s3_last_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] acc_shr;
  logic [DATA_W-1:0]       q16;
  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_value_r;
  logic [COL_W-1:0]        out_col_r;
  logic                    out_last_r;

  // Hold the whole pipe only when a column result cannot leave
  assign adv = !(s3_emit_r && out_valid_r && !res.ready);

  // Saturating accumulate; first element of a column starts from zero
  always_comb begin
    acc_base = s2_ctl_r.first ? '0 : acc_r;
    sum      = {acc_base[ACC_W-1], acc_base} + {prod_r[ACC_W-1], prod_r};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
  end

  // Floor shift by 16, then clamp to 32 bits
  always_comb begin
    acc_shr = acc_r >>> 16;
    if (acc_shr[ACC_W-1:DATA_W-1] == '0 || acc_shr[ACC_W-1:DATA_W-1] == '1) begin
      q16 = acc_shr[DATA_W-1:0];
    end else begin
      q16 = acc_shr[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_emit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s2_valid_r <= s1_valid;
        s3_emit_r  <= s2_valid_r && s2_ctl_r.col_end;
      end
      if (adv && s3_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r <= s1_ctl;
      prod_r   <= $signed(s1_vec) * $signed(s1_operand);
      s3_col_r  <= s2_ctl_r.col;
      s3_last_r <= s2_ctl_r.last;
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
      if (s3_emit_r) begin
        out_value_r <= q16;
        out_col_r   <= s3_col_r;
        out_last_r  <= s3_last_r;
      end
    end
  end

  assign res.valid        = out_valid_r;
  assign res.out_value    = out_value_r;
  assign res.column_index = out_col_r;
  assign res.last_column  = out_last_r;

endmodule
`default_nettype wire
